/* rtl/core/prd_pkg.sv */
`timescale 1ns / 1ps
package prd_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 18;
   localparam int LANES      = 3;

   localparam logic [1:0] CSR_INV_FOCAL_X = 2'd0;
   localparam logic [1:0] CSR_INV_FOCAL_Y = 2'd1;
   localparam logic [1:0] CSR_CENTER_X    = 2'd2;
   localparam logic [1:0] CSR_CENTER_Y    = 2'd3;

   localparam logic [24:0] FOCAL_RESET = 25'd16777216;
   localparam logic [16:0] ONE_Q16     = 17'd65536;

   typedef struct packed {
      logic        valid;
      logic        nx;
      logic        ny;
      logic [28:0] ax;
      logic [28:0] ay;
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [17:0] num;
      logic [17:0] quo;
      logic [32:0] den;
   } div_type;

endpackage

/* rtl/core/prd_front.sv */
`timescale 1ns / 1ps
module prd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [15:0]         pixel_col,
   input  logic [15:0]         pixel_row,
   input  logic [24:0]         inv_focal_x,
   input  logic [24:0]         inv_focal_y,
   input  logic [15:0]         center_x,
   input  logic [15:0]         center_y,
   output prd_pkg::sqrt_type   sqrt_out
);

   logic [4:0]  valid_ff;
   logic [4:0]  valid_in;
   logic [1:0]  neg_ff [5];
   logic [15:0] magx_ff, magy_ff;
   logic [40:0] prodx_ff, prody_ff;
   logic [28:0] ax_ff, ay_ff, ax2_ff, ay2_ff, ax3_ff, ay3_ff;
   logic [57:0] sqx_ff, sqy_ff;
   logic [63:0] rad_ff;

   assign valid_in = {valid_ff[3:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff[0] <= {pixel_row < center_y, pixel_col < center_x};
      magx_ff   <= (pixel_col >= center_x) ? pixel_col - center_x : center_x - pixel_col;
      magy_ff   <= (pixel_row >= center_y) ? pixel_row - center_y : center_y - pixel_row;
      neg_ff[1] <= neg_ff[0];
      prodx_ff  <= {25'd0, magx_ff} * {16'd0, inv_focal_x};
      prody_ff  <= {25'd0, magy_ff} * {16'd0, inv_focal_y};
      neg_ff[2] <= neg_ff[1];
      ax_ff     <= 29'((prodx_ff + 41'd2048) >> 12);
      ay_ff     <= 29'((prody_ff + 41'd2048) >> 12);
      neg_ff[3] <= neg_ff[2];
      ax2_ff    <= ax_ff;
      ay2_ff    <= ay_ff;
      sqx_ff    <= {29'd0, ax_ff} * {29'd0, ax_ff};
      sqy_ff    <= {29'd0, ay_ff} * {29'd0, ay_ff};
      neg_ff[4] <= neg_ff[3];
      ax3_ff    <= ax2_ff;
      ay3_ff    <= ay2_ff;
      rad_ff    <= ({6'd0, sqx_ff} + {6'd0, sqy_ff} + 64'h1_0000_0000) << 4;
   end

   always_comb begin
      sqrt_out       = '0;
      sqrt_out.valid = valid_ff[4];
      sqrt_out.nx    = neg_ff[4][0];
      sqrt_out.ny    = neg_ff[4][1];
      sqrt_out.ax    = ax3_ff;
      sqrt_out.ay    = ay3_ff;
      sqrt_out.rad   = rad_ff;
   end

endmodule

/* rtl/core/prd_sqrt_cell.sv */
`timescale 1ns / 1ps
module prd_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  prd_pkg::sqrt_type cell_in,
   output prd_pkg::sqrt_type cell_out
);

   prd_pkg::sqrt_type cell_ff;
   prd_pkg::sqrt_type cell_in_next;
   logic [34:0] pair;
   logic [34:0] trial;

   always_comb begin
      pair         = {cell_in.rem[32:0], cell_in.rad[63:62]};
      trial        = {1'b0, cell_in.root, 2'b01};
      cell_in_next = cell_in;
      cell_in_next.rad = {cell_in.rad[61:0], 2'b00};
      if (pair >= trial) begin
         cell_in_next.rem  = pair - trial;
         cell_in_next.root = {cell_in.root[30:0], 1'b1};
      end else begin
         cell_in_next.rem  = pair;
         cell_in_next.root = {cell_in.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in_next.valid;
      end
      cell_ff.nx   <= cell_in_next.nx;
      cell_ff.ny   <= cell_in_next.ny;
      cell_ff.ax   <= cell_in_next.ax;
      cell_ff.ay   <= cell_in_next.ay;
      cell_ff.rad  <= cell_in_next.rad;
      cell_ff.rem  <= cell_in_next.rem;
      cell_ff.root <= cell_in_next.root;
   end

   assign cell_out = cell_ff;

endmodule

/* rtl/core/prd_div_cell.sv */
`timescale 1ns / 1ps
module prd_div_cell (
   input  logic             clock,
   input  prd_pkg::div_type cell_in,
   output prd_pkg::div_type cell_out
);

   prd_pkg::div_type cell_ff;
   prd_pkg::div_type cell_in_next;
   logic [33:0] shifted;

   always_comb begin
      shifted      = {cell_in.rem[32:0], cell_in.num[17]};
      cell_in_next = cell_in;
      cell_in_next.num = {cell_in.num[16:0], 1'b0};
      if (shifted >= {1'b0, cell_in.den}) begin
         cell_in_next.rem = shifted - {1'b0, cell_in.den};
         cell_in_next.quo = {cell_in.quo[16:0], 1'b1};
      end else begin
         cell_in_next.rem = shifted;
         cell_in_next.quo = {cell_in.quo[16:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end

   assign cell_out = cell_ff;

endmodule

/* rtl/core/pinhole_ray_direction.sv */
`timescale 1ns / 1ps
// A request passes the front registers, the 32-cell square root chain, the divider input
// register, the 18-cell divider chains and the output register before rsp_valid rises.
// Throughput: one beat per cycle; busy is always low and start is taken every cycle.
// Each cell finishes one digit per cycle. The receiver cannot stall the output.
// Synchronous active-high reset clears all valid flags and restores the CSR registers to their defaults.
module pinhole_ray_direction (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_pixel_col,
   input  logic [15:0]        req_pixel_row,
   output logic               rsp_valid,
   output logic signed [17:0] rsp_dir_x,
   output logic signed [17:0] rsp_dir_y,
   output logic [16:0]        rsp_dir_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [24:0]        csr_wdata
);

   logic [24:0] inv_focal_x_ff, inv_focal_y_ff;
   logic [15:0] center_x_ff, center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_x_ff <= prd_pkg::FOCAL_RESET;
         inv_focal_y_ff <= prd_pkg::FOCAL_RESET;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            prd_pkg::CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata;
            prd_pkg::CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata;
            prd_pkg::CSR_CENTER_X:    center_x_ff    <= csr_wdata[15:0];
            prd_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   prd_pkg::sqrt_type sq_chain [prd_pkg::SQRT_STEPS + 1];

   prd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (start & ~busy),
      .pixel_col   (req_pixel_col),
      .pixel_row   (req_pixel_row),
      .inv_focal_x (inv_focal_x_ff),
      .inv_focal_y (inv_focal_y_ff),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .sqrt_out    (sq_chain[0])
   );

   for (genvar i = 0; i < prd_pkg::SQRT_STEPS; i++) begin : g_sqrt
      prd_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (sq_chain[i]),
         .cell_out (sq_chain[i + 1])
      );
   end

   prd_pkg::sqrt_type sq_last;
   logic [48:0]       num_x, num_y, num_z;
   prd_pkg::div_type  div_init [prd_pkg::LANES];
   prd_pkg::div_type  div_init_ff [prd_pkg::LANES];

   assign sq_last = sq_chain[prd_pkg::SQRT_STEPS];

   always_comb begin
      num_x = {1'b0, sq_last.ax, 19'd0} + {17'd0, sq_last.root};
      num_y = {1'b0, sq_last.ay, 19'd0} + {17'd0, sq_last.root};
      num_z = {13'd0, prd_pkg::ONE_Q16, 19'd0} + {17'd0, sq_last.root};
      div_init[0] = '{rem: {3'd0, num_x[48:18]}, num: num_x[17:0], quo: '0,
                      den: {sq_last.root, 1'b0}};
      div_init[1] = '{rem: {3'd0, num_y[48:18]}, num: num_y[17:0], quo: '0,
                      den: {sq_last.root, 1'b0}};
      div_init[2] = '{rem: {3'd0, num_z[48:18]}, num: num_z[17:0], quo: '0,
                      den: {sq_last.root, 1'b0}};
   end

   always_ff @(posedge clock) begin
      div_init_ff <= div_init;
   end

   logic [prd_pkg::DIV_STEPS + 1:0] valid_ff;
   logic [prd_pkg::DIV_STEPS + 1:0] valid_in;
   logic [1:0] sign_ff [prd_pkg::DIV_STEPS + 1];

   assign valid_in = {valid_ff[prd_pkg::DIV_STEPS:0], sq_last.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff[0] <= {sq_last.ny, sq_last.nx};
      for (int k = 1; k < prd_pkg::DIV_STEPS + 1; k++) begin
         sign_ff[k] <= sign_ff[k - 1];
      end
   end

   logic [17:0] quo [prd_pkg::LANES];

   for (genvar l = 0; l < prd_pkg::LANES; l++) begin : g_lane
      prd_pkg::div_type dv_chain [prd_pkg::DIV_STEPS + 1];
      assign dv_chain[0] = div_init_ff[l];
      for (genvar s = 0; s < prd_pkg::DIV_STEPS; s++) begin : g_step
         prd_div_cell u_cell (
            .clock    (clock),
            .cell_in  (dv_chain[s]),
            .cell_out (dv_chain[s + 1])
         );
      end
      assign quo[l] = dv_chain[prd_pkg::DIV_STEPS].quo;
   end

   logic [16:0] mag [prd_pkg::LANES];
   logic [1:0]  sign_last;
   logic signed [17:0] dir_x_ff, dir_y_ff;
   logic [16:0]        dir_z_ff;

   always_comb begin
      for (int l = 0; l < prd_pkg::LANES; l++) begin
         mag[l] = (quo[l] > {1'b0, prd_pkg::ONE_Q16}) ? prd_pkg::ONE_Q16 : quo[l][16:0];
      end
   end

   assign sign_last = sign_ff[prd_pkg::DIV_STEPS];

   always_ff @(posedge clock) begin
      dir_x_ff <= sign_last[0] ? -$signed({1'b0, mag[0]}) : $signed({1'b0, mag[0]});
      dir_y_ff <= sign_last[1] ? -$signed({1'b0, mag[1]}) : $signed({1'b0, mag[1]});
      dir_z_ff <= mag[2];
   end

   assign rsp_valid = valid_ff[prd_pkg::DIV_STEPS + 1];
   assign rsp_dir_x = dir_x_ff;
   assign rsp_dir_y = dir_y_ff;
   assign rsp_dir_z = dir_z_ff;

endmodule
